>>> design/sbi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbi_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// Field widths.
	localparam int FUNC_W    = 3;
	localparam int POS_W     = 32;
	localparam int SPD_W     = 16;
	localparam int WGT_W     = 17;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 4;

	// The weight has one integer bit and sixteen fraction bits.
	localparam int FRAC_W    = 16;
	localparam int DIV_STEPS = WGT_W;

	// Operation codes carried by a command beat.
	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT    = 3'd0,
		FN_REMOVE    = 3'd1,
		FN_SET_POS   = 3'd2,
		FN_SET_SPEED = 3'd3,
		FN_CLEAR     = 3'd4,
		FN_QUERY     = 3'd5
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_MIN = 4'd0,
		REG_RANGE_MAX = 4'd1
	} reg_idx_t;

	localparam logic signed [POS_W-1:0] RANGE_MIN_RST = 32'sd0;
	localparam logic signed [POS_W-1:0] RANGE_MAX_RST = 32'sd65536;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SPD_WAIT,
		S_REMOVE,
		S_INSERT,
		S_INS_HEAD,
		S_QUERY,
		S_DIVIDE,
		S_BLEND
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic signed [POS_W-1:0] position_in;
		logic signed [SPD_W-1:0] speed_in;
		logic [IDX_W-1:0]        entry_index;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic [IDX_W-1:0]        lower_index;
		logic [IDX_W-1:0]        upper_index;
		logic [WGT_W-1:0]        weight;
		logic signed [SPD_W-1:0] blended_speed;
		logic [CNT_W-1:0]        entry_count;
	} result_t;

endpackage

`default_nettype wire

>>> design/sorted_breakpoint_interpolator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted breakpoint table with piecewise-linear lookup, one command at a time.
// Clear, set speed and rejected commands answer in the cycle after start. Insert walks
// down from the top entry, remove walks up from the entry after the index, and set
// position fetches the speed, then removes and re-inserts. A query walks the table (one
// memory read a cycle), then runs the serial weight divider and the speed blend.
// The result is a one-cycle strobe and the receiver cannot stall it. Reset clears the
// entry count and the range registers; the table memory itself is not cleared.
module sorted_breakpoint_interpolator_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire sbi_pkg::cmd_t                     cmd,
	output logic                                   done,
	output sbi_pkg::result_t                       result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sbi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sbi_pkg::POS_W-1:0]         cfg_data
);

	localparam int IDX_W = sbi_pkg::IDX_W;
	localparam int CNT_W = sbi_pkg::CNT_W;
	localparam int POS_W = sbi_pkg::POS_W;
	localparam int SPD_W = sbi_pkg::SPD_W;

	// Table memories.
	logic signed [POS_W-1:0] pos_mem [sbi_pkg::MAX_ENTRIES];
	logic signed [SPD_W-1:0] spd_mem [sbi_pkg::MAX_ENTRIES];

	sbi_pkg::state_t         state_q, state_d;
	logic signed [POS_W-1:0] rmin_q, rmax_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        ptr_q;
	logic                    issue_q;
	logic signed [POS_W-1:0] pos_q;
	logic signed [SPD_W-1:0] spd_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    setpos_q;
	logic signed [POS_W-1:0] first_pos_q, prev_pos_q;
	logic signed [SPD_W-1:0] first_spd_q, prev_spd_q, slo_q, shi_q;
	logic [IDX_W-1:0]        lo_q, hi_q;
	logic                    done_q;
	sbi_pkg::result_t        res_q;

	// Registered memory read.
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic signed [POS_W-1:0] rd_pos_s1;
	logic signed [SPD_W-1:0] rd_spd_s1;

	// Command decode.
	logic                    accept;
	sbi_pkg::func_t          func;
	logic                    full;
	logic                    idx_ok;
	sbi_pkg::status_t        err_stat;
	logic signed [POS_W-1:0] v_lo, v_clamp;

	// Walk conditions.
	logic                    walking;
	logic                    q_first, q_hit, q_last, q_below;
	logic                    ins_shift;
	logic [CNT_W-1:0]        cnt_m1;

	// Sequencer outputs.
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en, wr_pos_en;
	logic [IDX_W-1:0]        wr_addr;
	logic signed [POS_W-1:0] wr_pos;
	logic signed [SPD_W-1:0] wr_spd;
	logic                    walk_load, walk_issue;
	logic [CNT_W-1:0]        walk_ptr;
	logic                    cnt_we;
	logic [CNT_W-1:0]        cnt_d;
	logic                    fin;
	sbi_pkg::result_t        res_d;

	// Arithmetic units.
	logic                    div_start, div_done;
	logic [POS_W-1:0]        div_num, div_den;
	logic [sbi_pkg::WGT_W-1:0] div_quo;
	logic                    bl_done;
	logic signed [SPD_W-1:0] bl_speed;

	assign busy      = state_q != sbi_pkg::S_IDLE;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign func      = sbi_pkg::func_t'(cmd.func);
	assign full      = cnt_q >= CNT_W'(sbi_pkg::MAX_ENTRIES);
	assign idx_ok    = (cnt_q != '0) && (CNT_W'(cmd.entry_index) < cnt_q);
	assign err_stat  = (cnt_q == '0) ? sbi_pkg::STAT_EMPTY : sbi_pkg::STAT_RANGE;
	assign cnt_m1    = cnt_q - CNT_W'(1);

	// Query value clamp: raise to the minimum first, then lower to the maximum.
	always_comb begin
		v_lo    = (cmd.position_in < rmin_q) ? rmin_q : cmd.position_in;
		v_clamp = (v_lo > rmax_q) ? rmax_q : v_lo;
	end

	// Conditions on the entry that the memory just returned.
	always_comb begin
		walking   = (state_q == sbi_pkg::S_REMOVE) || (state_q == sbi_pkg::S_INSERT)
			|| (state_q == sbi_pkg::S_QUERY);
		q_first   = rd_idx_s1 == '0;
		q_hit     = !q_first && (pos_q >= prev_pos_q) && (pos_q <= rd_pos_s1);
		q_last    = CNT_W'(rd_idx_s1) == cnt_m1;
		q_below   = pos_q <= (q_first ? rd_pos_s1 : first_pos_q);
		ins_shift = rd_pos_s1 > pos_q;
	end

	// Weight operands; both differences fit in 32 unsigned bits.
	assign div_num = pos_q - prev_pos_q;
	assign div_den = rd_pos_s1 - prev_pos_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sbi_pkg::S_IDLE: begin
				if (accept) begin
					case (func)
						sbi_pkg::FN_INSERT: begin
							if (!full) state_d = sbi_pkg::S_INSERT;
						end
						sbi_pkg::FN_REMOVE: begin
							if (idx_ok) state_d = sbi_pkg::S_REMOVE;
						end
						sbi_pkg::FN_SET_POS: begin
							if (idx_ok) state_d = sbi_pkg::S_SPD_WAIT;
						end
						sbi_pkg::FN_QUERY: begin
							if (cnt_q != '0) state_d = sbi_pkg::S_QUERY;
						end
						default: begin
							state_d = sbi_pkg::S_IDLE;
						end
					endcase
				end
			end
			sbi_pkg::S_SPD_WAIT: begin
				state_d = sbi_pkg::S_REMOVE;
			end
			sbi_pkg::S_REMOVE: begin
				if (!rd_vld_s1 && !issue_q)
					state_d = setpos_q ? sbi_pkg::S_INSERT : sbi_pkg::S_IDLE;
			end
			sbi_pkg::S_INSERT: begin
				if (rd_vld_s1) begin
					if (!ins_shift) state_d = sbi_pkg::S_IDLE;
					else if (rd_idx_s1 == '0) state_d = sbi_pkg::S_INS_HEAD;
				end else if (!issue_q) begin
					state_d = sbi_pkg::S_INS_HEAD;
				end
			end
			sbi_pkg::S_INS_HEAD: begin
				state_d = sbi_pkg::S_IDLE;
			end
			sbi_pkg::S_QUERY: begin
				if (rd_vld_s1) begin
					if (q_hit) state_d = sbi_pkg::S_DIVIDE;
					else if (q_last) state_d = sbi_pkg::S_IDLE;
				end
			end
			sbi_pkg::S_DIVIDE: begin
				if (div_done) state_d = sbi_pkg::S_BLEND;
			end
			sbi_pkg::S_BLEND: begin
				if (bl_done) state_d = sbi_pkg::S_IDLE;
			end
			default: begin
				state_d = sbi_pkg::S_IDLE;
			end
		endcase
	end

	// Sequencer outputs: memory port, walk setup, count update and result.
	always_comb begin
		rd_en      = walking && issue_q;
		rd_addr    = ptr_q[IDX_W-1:0];
		wr_en      = 1'b0;
		wr_pos_en  = 1'b1;
		wr_addr    = rd_idx_s1;
		wr_pos     = rd_pos_s1;
		wr_spd     = rd_spd_s1;
		walk_load  = 1'b0;
		walk_issue = 1'b0;
		walk_ptr   = '0;
		cnt_we     = 1'b0;
		cnt_d      = cnt_q;
		div_start  = 1'b0;
		fin        = 1'b0;
		res_d      = '0;
		res_d.status      = sbi_pkg::STAT_OK;
		res_d.entry_count = cnt_q;
		case (state_q)
			sbi_pkg::S_IDLE: begin
				rd_addr = cmd.entry_index;
				if (accept) begin
					case (func)
						sbi_pkg::FN_INSERT: begin
							if (full) begin
								fin          = 1'b1;
								res_d.status = sbi_pkg::STAT_FULL;
							end else begin
								walk_load  = 1'b1;
								walk_ptr   = cnt_m1;
								walk_issue = cnt_q != '0;
							end
						end
						sbi_pkg::FN_REMOVE: begin
							if (!idx_ok) begin
								fin          = 1'b1;
								res_d.status = err_stat;
							end else begin
								walk_load  = 1'b1;
								walk_ptr   = CNT_W'(cmd.entry_index) + CNT_W'(1);
								walk_issue = walk_ptr < cnt_q;
							end
						end
						sbi_pkg::FN_SET_POS: begin
							// Fetch the speed that travels with the moved entry.
							if (!idx_ok) begin
								fin          = 1'b1;
								res_d.status = err_stat;
							end else begin
								rd_en = 1'b1;
							end
						end
						sbi_pkg::FN_SET_SPEED: begin
							fin = 1'b1;
							if (!idx_ok) begin
								res_d.status = err_stat;
							end else begin
								wr_en     = 1'b1;
								wr_pos_en = 1'b0;
								wr_addr   = cmd.entry_index;
								wr_spd    = cmd.speed_in;
							end
						end
						sbi_pkg::FN_CLEAR: begin
							fin               = 1'b1;
							cnt_we            = 1'b1;
							cnt_d             = '0;
							res_d.entry_count = '0;
						end
						sbi_pkg::FN_QUERY: begin
							if (cnt_q == '0) begin
								fin          = 1'b1;
								res_d.status = sbi_pkg::STAT_EMPTY;
							end else begin
								walk_load  = 1'b1;
								walk_ptr   = '0;
								walk_issue = 1'b1;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			sbi_pkg::S_SPD_WAIT: begin
				walk_load  = 1'b1;
				walk_ptr   = CNT_W'(idx_q) + CNT_W'(1);
				walk_issue = walk_ptr < cnt_q;
			end
			sbi_pkg::S_REMOVE: begin
				// Each later entry moves down by one.
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = rd_idx_s1 - IDX_W'(1);
				end else if (!issue_q) begin
					cnt_we = 1'b1;
					cnt_d  = cnt_m1;
					if (setpos_q) begin
						walk_load  = 1'b1;
						walk_ptr   = cnt_m1 - CNT_W'(1);
						walk_issue = cnt_m1 != '0;
					end else begin
						fin               = 1'b1;
						res_d.entry_count = cnt_m1;
					end
				end
			end
			sbi_pkg::S_INSERT: begin
				// Walk down from the top: larger entries move up, the new one lands
				// just above the first entry not greater than it.
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = rd_idx_s1 + IDX_W'(1);
					if (!ins_shift) begin
						wr_pos            = pos_q;
						wr_spd            = spd_q;
						fin               = 1'b1;
						cnt_we            = 1'b1;
						cnt_d             = cnt_q + CNT_W'(1);
						res_d.entry_count = cnt_d;
					end
				end
			end
			sbi_pkg::S_INS_HEAD: begin
				wr_en             = 1'b1;
				wr_addr           = '0;
				wr_pos            = pos_q;
				wr_spd            = spd_q;
				fin               = 1'b1;
				cnt_we            = 1'b1;
				cnt_d             = cnt_q + CNT_W'(1);
				res_d.entry_count = cnt_d;
			end
			sbi_pkg::S_QUERY: begin
				if (rd_vld_s1) begin
					if (q_hit) begin
						div_start = 1'b1;
					end else if (q_last) begin
						// Outside every pair: clamp to the first or last entry.
						fin = 1'b1;
						if (q_below) begin
							res_d.lower_index   = '0;
							res_d.upper_index   = '0;
							res_d.blended_speed = q_first ? rd_spd_s1 : first_spd_q;
						end else begin
							res_d.lower_index   = IDX_W'(cnt_m1);
							res_d.upper_index   = IDX_W'(cnt_m1);
							res_d.blended_speed = rd_spd_s1;
						end
					end
				end
			end
			sbi_pkg::S_DIVIDE: begin
				rd_en = 1'b0;
			end
			sbi_pkg::S_BLEND: begin
				if (bl_done) begin
					fin                 = 1'b1;
					res_d.lower_index   = lo_q;
					res_d.upper_index   = hi_q;
					res_d.weight        = div_quo;
					res_d.blended_speed = bl_speed;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			spd_mem[wr_addr] <= wr_spd;
			if (wr_pos_en) pos_mem[wr_addr] <= wr_pos;
		end
		if (rd_en) begin
			rd_pos_s1 <= pos_mem[rd_addr];
			rd_spd_s1 <= spd_mem[rd_addr];
			rd_idx_s1 <= rd_addr;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sbi_pkg::S_IDLE;
			cnt_q     <= '0;
			ptr_q     <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
			rmin_q    <= sbi_pkg::RANGE_MIN_RST;
			rmax_q    <= sbi_pkg::RANGE_MAX_RST;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			done_q    <= fin;
			if (cnt_we) cnt_q <= cnt_d;
			// Read pointer: downward for insert, upward otherwise.
			if (walk_load) begin
				ptr_q   <= walk_ptr;
				issue_q <= walk_issue;
			end else if (rd_en && walking) begin
				if (state_q == sbi_pkg::S_INSERT) begin
					if (ptr_q == '0) issue_q <= 1'b0;
					else ptr_q <= ptr_q - CNT_W'(1);
				end else begin
					if (ptr_q == cnt_m1) issue_q <= 1'b0;
					else ptr_q <= ptr_q + CNT_W'(1);
				end
			end
			// Configuration beats.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sbi_pkg::REG_RANGE_MIN: rmin_q <= cfg_data;
					sbi_pkg::REG_RANGE_MAX: rmax_q <= cfg_data;
					default: begin
						rmin_q <= rmin_q;
					end
				endcase
			end
		end
	end

	// Operand and walk registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q    <= (func == sbi_pkg::FN_QUERY) ? v_clamp : cmd.position_in;
			spd_q    <= cmd.speed_in;
			idx_q    <= cmd.entry_index;
			setpos_q <= func == sbi_pkg::FN_SET_POS;
		end
		if (state_q == sbi_pkg::S_SPD_WAIT) spd_q <= rd_spd_s1;
		if ((state_q == sbi_pkg::S_QUERY) && rd_vld_s1) begin
			prev_pos_q <= rd_pos_s1;
			prev_spd_q <= rd_spd_s1;
			if (q_first) begin
				first_pos_q <= rd_pos_s1;
				first_spd_q <= rd_spd_s1;
			end
			if (q_hit) begin
				lo_q  <= rd_idx_s1 - IDX_W'(1);
				hi_q  <= rd_idx_s1;
				slo_q <= prev_spd_q;
				shi_q <= rd_spd_s1;
			end
		end
		if (fin) res_q <= res_d;
	end

	sbi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	sbi_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_done),
		.spd_lo (slo_q),
		.spd_hi (shi_q),
		.weight (div_quo),
		.done   (bl_done),
		.speed  (bl_speed)
	);

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

>>> design/sbi_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider for the interpolation weight. The numerator never exceeds
// the denominator, so the quotient of (num << 16) / den fits in 17 bits and
// comes out one bit per cycle. A zero denominator yields a zero quotient.
module sbi_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [sbi_pkg::POS_W-1:0]    num,
	input  wire logic [sbi_pkg::POS_W-1:0]    den,
	output logic                              done,
	output logic [sbi_pkg::WGT_W-1:0]         quo
);

	localparam int STEP_W = $clog2(sbi_pkg::DIV_STEPS);

	logic                          busy_q;
	logic                          done_q;
	logic                          zero_q;
	logic [STEP_W-1:0]             step_q;
	logic [sbi_pkg::POS_W:0]       rem_q;
	logic [sbi_pkg::POS_W-1:0]     den_q;
	logic [sbi_pkg::WGT_W-1:0]     quo_q;

	logic                          ge;
	logic [sbi_pkg::POS_W:0]       diff;

	// One trial subtraction per cycle.
	always_comb begin
		ge   = rem_q >= {1'b0, den_q};
		diff = ge ? (rem_q - {1'b0, den_q}) : rem_q;
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(sbi_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			zero_q <= den == '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= {diff[sbi_pkg::POS_W-1:0], 1'b0};
			quo_q <= {quo_q[sbi_pkg::WGT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = zero_q ? '0 : quo_q;

endmodule

`default_nettype wire

>>> design/sbi_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Blends the lower speed toward the upper speed by the weight:
// lo + floor((hi - lo) * w / 65536). Multiply in the first stage, add in the second.
module sbi_blend (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic signed [sbi_pkg::SPD_W-1:0] spd_lo,
	input  wire logic signed [sbi_pkg::SPD_W-1:0] spd_hi,
	input  wire logic [sbi_pkg::WGT_W-1:0]        weight,
	output logic                                  done,
	output logic signed [sbi_pkg::SPD_W-1:0]      speed
);

	localparam int DIFF_W = sbi_pkg::SPD_W + 1;
	localparam int PROD_W = DIFF_W + sbi_pkg::WGT_W + 1;
	localparam int SHR_W  = PROD_W - sbi_pkg::FRAC_W;

	logic signed [DIFF_W-1:0]           diff;
	logic signed [sbi_pkg::WGT_W:0]     wsig;
	logic signed [PROD_W-1:0]           prod;
	logic signed [SHR_W-1:0]            sum;

	logic                               vld_s1;
	logic signed [PROD_W-1:0]           prod_s1;
	logic signed [sbi_pkg::SPD_W-1:0]   lo_s1;
	logic                               done_s2;
	logic signed [sbi_pkg::SPD_W-1:0]   speed_s2;

	// Speed difference times weight.
	always_comb begin
		diff = {spd_hi[sbi_pkg::SPD_W-1], spd_hi} - {spd_lo[sbi_pkg::SPD_W-1], spd_lo};
		wsig = {1'b0, weight};
		prod = diff * wsig;
	end

	// The upper bits of the product are the floored quotient by 65536.
	always_comb begin
		sum = {{(SHR_W - sbi_pkg::SPD_W){lo_s1[sbi_pkg::SPD_W-1]}}, lo_s1}
			+ prod_s1[PROD_W-1:sbi_pkg::FRAC_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1  <= start;
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= prod;
			lo_s1   <= spd_lo;
		end
		if (vld_s1) begin
			speed_s2 <= sum[sbi_pkg::SPD_W-1:0];
		end
	end

	assign done  = done_s2;
	assign speed = speed_s2;

endmodule

`default_nettype wire

>>> test/sorted_breakpoint_interpolator_unit_tb.sv
`timescale 1ns / 1ps

module sorted_breakpoint_interpolator_unit_tb;
	import sbi_pkg::*;

	// Function codes the block treats as no operation.
	localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

	localparam int CYCLE_LIMIT     = 600000;
	localparam int SETTLE_CYCLES   = 60;
	localparam int MAX_REPORTS     = 200;
	localparam int ITEMS_PER_PHASE = 170;

	localparam logic signed [POS_W-1:0] POS_LOWEST  = 32'sh8000_0000;
	localparam logic signed [POS_W-1:0] POS_HIGHEST = 32'sh7fff_ffff;
	localparam logic signed [SPD_W-1:0] SPD_LOWEST  = 16'sh8000;
	localparam logic signed [SPD_W-1:0] SPD_HIGHEST = 16'sh7fff;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	cmd_t                 cmd;
	logic                 done;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [POS_W-1:0]     cfg_data;

	// Mirror of the breakpoint table and the query clamp.
	logic signed [POS_W-1:0] bp_pos [MAX_ENTRIES];
	logic signed [SPD_W-1:0] bp_spd [MAX_ENTRIES];
	int                      bp_count;
	logic signed [POS_W-1:0] clamp_lo;
	logic signed [POS_W-1:0] clamp_hi;

	// Expected results still owed by the block, oldest first.
	result_t pending_results[$];
	int      mismatches = 0;
	int      cycle_count = 0;

	sorted_breakpoint_interpolator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Close the gap left by a removed entry.
	function automatic void drop_entry(int at);
		for (int i = at; i + 1 < bp_count; i++) begin
			bp_pos[i] = bp_pos[i + 1];
			bp_spd[i] = bp_spd[i + 1];
		end
		bp_count--;
	endfunction

	// A new entry goes after every entry whose position is less or equal.
	function automatic void place_entry(logic signed [POS_W-1:0] p, logic signed [SPD_W-1:0] s);
		int at;
		at = 0;
		while (at < bp_count && bp_pos[at] <= p)
			at++;
		for (int i = bp_count; i > at; i--) begin
			bp_pos[i] = bp_pos[i - 1];
			bp_spd[i] = bp_spd[i - 1];
		end
		bp_pos[at] = p;
		bp_spd[at] = s;
		bp_count++;
	endfunction

	// Apply one command to the mirror table and return the result it should produce.
	function automatic result_t apply_command(cmd_t c);
		result_t                 r;
		logic signed [POS_W-1:0] v;
		logic signed [SPD_W-1:0] keep;
		longint                  span;
		longint                  offs;
		longint                  prod;
		bit                      found;
		r = '0;
		case (c.func)
			FN_INSERT: begin
				if (bp_count >= MAX_ENTRIES)
					r.status = STAT_FULL;
				else
					place_entry(c.position_in, c.speed_in);
			end
			FN_REMOVE, FN_SET_POS, FN_SET_SPEED: begin
				if (bp_count == 0) begin
					r.status = STAT_EMPTY;
				end else if (c.entry_index >= bp_count) begin
					r.status = STAT_RANGE;
				end else if (c.func == FN_REMOVE) begin
					drop_entry(c.entry_index);
				end else if (c.func == FN_SET_POS) begin
					keep = bp_spd[c.entry_index];
					drop_entry(c.entry_index);
					place_entry(c.position_in, keep);
				end else begin
					bp_spd[c.entry_index] = c.speed_in;
				end
			end
			FN_CLEAR: bp_count = 0;
			FN_QUERY: begin
				if (bp_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					// Raise to the lower bound first, so the upper bound wins when inverted.
					v = c.position_in;
					if (v < clamp_lo)
						v = clamp_lo;
					if (v > clamp_hi)
						v = clamp_hi;
					found = 1'b0;
					for (int i = 0; i + 1 < bp_count && !found; i++) begin
						if (v >= bp_pos[i] && v <= bp_pos[i + 1]) begin
							found = 1'b1;
							r.lower_index = i;
							r.upper_index = i + 1;
							span = longint'(bp_pos[i + 1]) - longint'(bp_pos[i]);
							offs = longint'(v) - longint'(bp_pos[i]);
							if (span > 0)
								r.weight = (offs <<< 16) / span;
						end
					end
					// Outside the table the lookup sticks to the nearer end.
					if (!found && bp_count > 1 && v > bp_pos[0]) begin
						r.lower_index = bp_count - 1;
						r.upper_index = bp_count - 1;
					end
					if (r.lower_index != r.upper_index) begin
						prod = (longint'(bp_spd[r.upper_index]) - longint'(bp_spd[r.lower_index]))
							* longint'(r.weight);
						r.blended_speed = bp_spd[r.lower_index] + (prod >>> 16);
					end else begin
						r.blended_speed = bp_spd[r.lower_index];
					end
				end
			end
			default: ;
		endcase
		r.entry_count = bp_count;
		return r;
	endfunction

	function automatic cmd_t make_cmd(logic [FUNC_W-1:0] f, logic signed [POS_W-1:0] p,
			logic signed [SPD_W-1:0] s, logic [IDX_W-1:0] i);
		cmd_t c;
		c.func        = f;
		c.position_in = p;
		c.speed_in    = s;
		c.entry_index = i;
		return c;
	endfunction

	// Positions lean toward the clamp window, the table contents and the extremes.
	function automatic logic signed [POS_W-1:0] pick_position();
		longint span;
		span = longint'(clamp_hi) - longint'(clamp_lo);
		case ($urandom_range(0, 6))
			0: return $urandom;
			1: return (bp_count > 0) ? bp_pos[$urandom_range(0, bp_count - 1)] : $urandom;
			2: return ($urandom_range(0, 1) != 0) ? POS_LOWEST : POS_HIGHEST;
			3: return clamp_lo + $urandom_range(0, 3);
			4: return clamp_hi - $urandom_range(0, 3);
			default: begin
				if (span <= 0)
					return clamp_hi - 256 + $urandom_range(0, 512);
				return longint'(clamp_lo) + ({$urandom, $urandom} % (span + 1));
			end
		endcase
	endfunction

	// Mostly well-formed commands on live entries, with some noise mixed in.
	function automatic cmd_t random_command();
		cmd_t c;
		int   roll;
		roll = $urandom_range(0, 99);
		c.position_in = pick_position();
		c.speed_in    = $urandom;
		if (bp_count > 0 && $urandom_range(0, 6) != 0)
			c.entry_index = $urandom_range(0, bp_count - 1);
		else
			c.entry_index = $urandom_range(0, 15);
		if (roll < 30)
			c.func = FN_INSERT;
		else if (roll < 40)
			c.func = FN_REMOVE;
		else if (roll < 50)
			c.func = FN_SET_POS;
		else if (roll < 60)
			c.func = FN_SET_SPEED;
		else if (roll < 62)
			c.func = FN_CLEAR;
		else if (roll < 64)
			c.func = ($urandom_range(0, 1) != 0) ? FN_SPARE_A : FN_SPARE_B;
		else
			c.func = FN_QUERY;
		return c;
	endfunction

	// Present one command beat and wait for the block to take it.
	task automatic send_command(cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_command(c));
	endtask

	// Drop start for a random stretch; a zero length keeps commands back to back.
	task automatic pause_sender();
		int gap;
		case ($urandom_range(0, 3))
			0: gap = 0;
			1: gap = $urandom_range(1, 3);
			2: gap = $urandom_range(4, 15);
			default: gap = $urandom_range(16, 50);
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Both clamp registers are written back to back on an idle block.
	task automatic set_query_range(logic signed [POS_W-1:0] lo, logic signed [POS_W-1:0] hi);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_index <= REG_RANGE_MIN;
		cfg_data  <= lo;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_RANGE_MAX;
		cfg_data  <= hi;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		clamp_lo = lo;
		clamp_hi = hi;
		@(posedge clk);
	endtask

	task automatic test_directed_ops();
		// Empty table, still under the reset clamp window.
		send_command(make_cmd(FN_QUERY, 32'sh0000_4000, 16'sh0000, 4'd0));
		send_command(make_cmd(FN_REMOVE, 32'sh0000_0000, 16'sh0000, 4'd0));
		send_command(make_cmd(FN_SET_POS, 32'sh0000_1000, 16'sh0000, 4'd15));
		send_command(make_cmd(FN_SET_SPEED, 32'sh0000_0000, 16'sh0100, 4'd0));
		send_command(make_cmd(FN_INSERT, 32'sh0000_8000, 16'sh0100, 4'd0));
		send_command(make_cmd(FN_INSERT, 32'sh0001_8000, 16'sh0300, 4'd0));
		// One query clamped down to the reset upper bound, one up to the lower bound.
		send_command(make_cmd(FN_QUERY, 32'sh0002_0000, 16'sh0000, 4'd0));
		send_command(make_cmd(FN_QUERY, -32'sd5, 16'sh0000, 4'd0));
		// Indexes past the last entry.
		send_command(make_cmd(FN_REMOVE, 32'sh0000_0000, 16'sh0000, 4'd2));
		send_command(make_cmd(FN_SET_POS, 32'sh0000_0000, 16'sh0000, 4'd15));
		send_command(make_cmd(FN_SET_SPEED, 32'sh0000_0000, 16'sh0000, 4'd2));
		send_command(make_cmd(FN_CLEAR, 32'sh0000_0000, 16'sh0000, 4'd0));

		set_query_range(POS_LOWEST, POS_HIGHEST);
		// A single entry, then a pair spanning the whole position range.
		send_command(make_cmd(FN_INSERT, POS_HIGHEST, SPD_HIGHEST, 4'd0));
		send_command(make_cmd(FN_QUERY, 32'sh0000_0000, 16'sh0000, 4'd0));
		send_command(make_cmd(FN_INSERT, POS_LOWEST, SPD_LOWEST, 4'd0));
		send_command(make_cmd(FN_QUERY, POS_HIGHEST, 16'sh0000, 4'd0));
		send_command(make_cmd(FN_QUERY, 32'sh0000_0000, 16'sh0000, 4'd0));
		// Equal positions, then a zero-width pair at the head of the table.
		send_command(make_cmd(FN_INSERT, 32'sh0000_0000, 16'sd100, 4'd0));
		send_command(make_cmd(FN_INSERT, 32'sh0000_0000, -16'sd100, 4'd0));
		send_command(make_cmd(FN_QUERY, 32'sh0000_0000, 16'sh0000, 4'd0));
		send_command(make_cmd(FN_SET_POS, 32'sh0000_0000, 16'sh0000, 4'd0));
		send_command(make_cmd(FN_QUERY, 32'sh0000_0000, 16'sh0000, 4'd0));
		send_command(make_cmd(FN_SET_SPEED, 32'sh0000_0000, 16'sh5555, 4'd3));
		send_command(make_cmd(FN_SPARE_A, POS_HIGHEST, SPD_HIGHEST, 4'd15));
		send_command(make_cmd(FN_SPARE_B, POS_LOWEST, SPD_LOWEST, 4'd0));
		send_command(make_cmd(FN_REMOVE, 32'sh0000_0000, 16'sh0000, 4'd1));
		send_command(make_cmd(FN_QUERY, POS_LOWEST, 16'sh0000, 4'd0));
	endtask

	// Fill the table to the brim, overflow it once, then work on the last slot.
	task automatic test_table_capacity();
		set_query_range(-32'sh0004_0000, 32'sh0004_0000);
		send_command(make_cmd(FN_CLEAR, 32'sh0000_0000, 16'sh0000, 4'd0));
		for (int n = 0; n <= MAX_ENTRIES; n++)
			send_command(make_cmd(FN_INSERT, pick_position(), $urandom, 4'd0));
		send_command(make_cmd(FN_QUERY, pick_position(), 16'sh0000, 4'd0));
		send_command(make_cmd(FN_SET_POS, pick_position(), 16'sh0000, 4'd15));
		send_command(make_cmd(FN_QUERY, pick_position(), 16'sh0000, 4'd0));
		send_command(make_cmd(FN_REMOVE, 32'sh0000_0000, 16'sh0000, 4'd15));
		send_command(make_cmd(FN_QUERY, pick_position(), 16'sh0000, 4'd0));
	endtask

	// Random traffic in bursts, one phase per clamp window.
	task automatic test_random_traffic();
		int                      burst_left;
		logic signed [POS_W-1:0] a;
		logic signed [POS_W-1:0] b;
		burst_left = 0;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_query_range(POS_LOWEST, POS_HIGHEST);
				1: set_query_range(RANGE_MIN_RST, RANGE_MAX_RST);
				2: set_query_range(32'sh0002_0000, -32'sh0001_0000);
				3: begin
					a = $urandom;
					b = $urandom;
					if (a <= b)
						set_query_range(a, b);
					else
						set_query_range(b, a);
				end
				4: set_query_range(POS_HIGHEST, POS_LOWEST);
				default: set_query_range(-32'sh0010_0000, 32'sh0010_0000);
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (burst_left == 0) begin
					pause_sender();
					if ($urandom_range(0, 9) == 0)
						burst_left = $urandom_range(40, 120);
					else
						burst_left = $urandom_range(1, 12);
				end
				// Now and then hold off until the block has answered everything.
				if ($urandom_range(0, 99) == 0)
					wait_for_results();
				send_command(random_command());
				burst_left--;
			end
		end
	endtask

	// Every result beat is checked against the oldest outstanding expected result.
	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s differs, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with no command outstanding, expected none, got %p",
					$time, result);
			end else begin
				want = pending_results.pop_front();
				compare_field("status", want.status, result.status);
				compare_field("lower_index", want.lower_index, result.lower_index);
				compare_field("upper_index", want.upper_index, result.upper_index);
				compare_field("weight", want.weight, result.weight);
				compare_field("blended_speed", want.blended_speed, result.blended_speed);
				compare_field("entry_count", want.entry_count, result.entry_count);
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		bp_count = 0;
		clamp_lo = RANGE_MIN_RST;
		clamp_hi = RANGE_MAX_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_table_capacity();
		test_random_traffic();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
design/sbi_pkg.sv
design/sbi_div.sv
design/sbi_blend.sv
design/sorted_breakpoint_interpolator_unit.sv
test/sorted_breakpoint_interpolator_unit_tb.sv
